/* design/gdo_pkg.sv */
// shared types, constants and calendar tables for the gregorian date offset block
package gdo_pkg;

    localparam int SY_W  = 14;
    localparam int MON_W = 4;
    localparam int DAY_W = 5;
    localparam int WD_W  = 3;

    localparam int YEAR_W    = 16;
    localparam int YMOD_W    = 9;
    localparam int DAY_MIN_W = 19;

    localparam int CYCLE_DAYS  = 146097;
    localparam int CYCLE_YEARS = 400;
    localparam int YEAR_MIN    = 1;
    localparam int YEAR_MAX    = 9999;

    localparam int MONTH_JAN = 1;
    localparam int MONTH_FEB = 2;
    localparam int MONTH_DEC = 12;

    localparam int DIV100_MUL   = 5243;
    localparam int DIV400_SHIFT = 21;
    localparam int DIV7_MUL     = 37450;
    localparam int YMOD_LAST    = 399;

    typedef struct packed {
        logic back;
        logic cycle;
    } t_step_ctl;

    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        logic cent;
        cent = (ymod == 9'd0) || (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
        return ((ymod[1:0] == 2'd0) && !cent) || (ymod == 9'd0);
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // (13*m+8)/5 with january and february as months 13 and 14
    function automatic logic [5:0] month_term(input logic [MON_W-1:0] m);
        logic [5:0] t;
        case (m)
            4'd1:    t = 6'd35;
            4'd2:    t = 6'd38;
            4'd3:    t = 6'd9;
            4'd4:    t = 6'd12;
            4'd5:    t = 6'd14;
            4'd6:    t = 6'd17;
            4'd7:    t = 6'd19;
            4'd8:    t = 6'd22;
            4'd9:    t = 6'd25;
            4'd10:   t = 6'd27;
            4'd11:   t = 6'd30;
            4'd12:   t = 6'd32;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

/* design/gregorian_date_offset_top.sv */
// top level: date offset sequencer, output register and checks
// Moves a Gregorian date forward (operation 0) or back (operation 1) by the
// magnitude of a signed day count and returns the new date with its weekday
// (0 = Sunday). One beat is taken at a time and o_in_stall stays high until
// its result has been loaded into the output register. From the accepting
// edge an item goes through loading and reducing the year, c steps of the
// shared day adder that skip whole 400-year cycles and one that finds no
// more to skip, k steps that walk one month each and one that finds the
// walk done, and the weekday pipeline; an invalid month goes straight to the
// error state. With the default 16-bit count c is 0 and k stays below about
// 1080. A finished result waits while i_out_stall holds the output register;
// the walk ends early once the year has left 1..9999 for good. Out-of-range
// results repeat the start date with range_error set and weekday 0.
module gregorian_date_offset_top
    import gdo_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [SY_W-1:0]               i_start_year,
    input  logic [MON_W-1:0]              i_start_month,
    input  logic [DAY_W-1:0]              i_start_day,
    input  logic signed [OFFSET_BITS-1:0] i_day_offset,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [SY_W-1:0]               o_end_year,
    output logic [MON_W-1:0]              o_end_month,
    output logic [DAY_W-1:0]              o_end_day,
    output logic [WD_W-1:0]               o_weekday,
    output logic                          o_range_error
);

    localparam int DW = (OFFSET_BITS + 1 > DAY_MIN_W) ? OFFSET_BITS + 1 : DAY_MIN_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INIT0 = 7'b0000010,
        S_INIT1 = 7'b0000100,
        S_CYC   = 7'b0001000,
        S_MON   = 7'b0010000,
        S_WDAY  = 7'b0100000,
        S_ERR   = 7'b1000000
    } t_state;

    t_state                    r_state, n_state;
    logic                      r_back, n_back;
    logic signed [YEAR_W-1:0]  r_y, n_y;
    logic [MON_W-1:0]          r_m, n_m;
    logic signed [DW-1:0]      r_d, n_d;
    logic [YMOD_W-1:0]         r_ymod, n_ymod;
    logic [5:0]                r_q400, n_q400;
    logic [SY_W-1:0]           r_sy, n_sy;
    logic [MON_W-1:0]          r_sm, n_sm;
    logic [DAY_W-1:0]          r_sd, n_sd;
    logic [1:0]                r_wcnt, n_wcnt;

    logic                      r_ovalid, n_ovalid;
    logic [SY_W-1:0]           r_oyear, n_oyear;
    logic [MON_W-1:0]          r_omonth, n_omonth;
    logic [DAY_W-1:0]          r_oday, n_oday;
    logic [WD_W-1:0]           r_oweek, n_oweek;
    logic                      r_oerr, n_oerr;

    logic [OFFSET_BITS-1:0]    mag;
    logic signed [DW-1:0]      day_ext;
    logic signed [DW-1:0]      mag_ext;
    logic [26:0]               y_prod;
    logic                      accept;
    logic                      out_free;
    logic                      err_now;
    logic                      out_of_range;
    t_step_ctl                 step_ctl;
    logic signed [DW-1:0]      step_day;
    logic                      step_more;
    logic [WD_W-1:0]           wd;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;

    // magnitude of the count, the most negative value included
    assign mag     = i_day_offset[OFFSET_BITS-1] ? unsigned'(-i_day_offset)
                                                 : unsigned'(i_day_offset);
    assign day_ext = {{(DW-DAY_W){1'b0}}, i_start_day};
    assign mag_ext = {{(DW-OFFSET_BITS){1'b0}}, mag};
    assign y_prod  = {13'b0, r_sy} * 27'(DIV100_MUL);

    assign out_of_range = (r_y < YEAR_MIN) || (r_y > YEAR_MAX);
    assign err_now      = r_back ? (r_y < YEAR_MIN) : (r_y > YEAR_MAX);

    assign step_ctl.back  = r_back;
    assign step_ctl.cycle = (r_state == S_CYC);

    gdo_step_unit #(
        .DW(DW)
    ) u_step (
        .i_ctl      (step_ctl),
        .i_month    (r_m),
        .i_ymod     (r_ymod),
        .i_day      (r_d),
        .o_day_next (step_day),
        .o_more     (step_more)
    );

    gdo_weekday u_weekday (
        .i_clk     (i_clk),
        .i_year    (r_y[SY_W-1:0]),
        .i_month   (r_m),
        .i_day     (r_d[DAY_W-1:0]),
        .o_weekday (wd)
    );

    always_comb begin
        n_state  = r_state;
        n_back   = r_back;
        n_y      = r_y;
        n_m      = r_m;
        n_d      = r_d;
        n_ymod   = r_ymod;
        n_q400   = r_q400;
        n_sy     = r_sy;
        n_sm     = r_sm;
        n_sd     = r_sd;
        n_wcnt   = r_wcnt;
        n_ovalid = r_ovalid && i_out_stall;
        n_oyear  = r_oyear;
        n_omonth = r_omonth;
        n_oday   = r_oday;
        n_oweek  = r_oweek;
        n_oerr   = r_oerr;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_back = i_operation;
                    n_sy   = i_start_year;
                    n_sm   = i_start_month;
                    n_sd   = i_start_day;
                    n_y    = {2'b0, i_start_year};
                    n_m    = i_start_month;
                    n_d    = i_operation ? day_ext - mag_ext : day_ext + mag_ext;
                    if ((i_start_month == '0) || (i_start_month > MON_W'(MONTH_DEC))) begin
                        n_state = S_ERR;
                    end else begin
                        n_state = S_INIT0;
                    end
                end
            end
            S_INIT0: begin
                n_q400  = y_prod[DIV400_SHIFT+5:DIV400_SHIFT];
                n_state = S_INIT1;
            end
            S_INIT1: begin
                n_ymod  = YMOD_W'(r_sy - ({8'b0, r_q400} * 14'd400));
                n_state = S_CYC;
            end
            S_CYC: begin
                if (err_now) begin
                    n_state = S_ERR;
                end else if (step_more) begin
                    n_d = step_day;
                    n_y = r_back ? r_y - YEAR_W'(CYCLE_YEARS) : r_y + YEAR_W'(CYCLE_YEARS);
                end else begin
                    n_state = S_MON;
                end
            end
            S_MON: begin
                if (err_now) begin
                    n_state = S_ERR;
                end else if (step_more) begin
                    n_d = step_day;
                    if (r_back) begin
                        if (r_m == MON_W'(MONTH_JAN)) begin
                            n_m    = MON_W'(MONTH_DEC);
                            n_y    = r_y - 16'sd1;
                            n_ymod = (r_ymod == '0) ? YMOD_W'(YMOD_LAST) : r_ymod - 9'd1;
                        end else begin
                            n_m = r_m - 4'd1;
                        end
                    end else begin
                        if (r_m == MON_W'(MONTH_DEC)) begin
                            n_m    = MON_W'(MONTH_JAN);
                            n_y    = r_y + 16'sd1;
                            n_ymod = (r_ymod == YMOD_W'(YMOD_LAST)) ? '0 : r_ymod + 9'd1;
                        end else begin
                            n_m = r_m + 4'd1;
                        end
                    end
                end else if (out_of_range) begin
                    n_state = S_ERR;
                end else begin
                    n_wcnt  = '0;
                    n_state = S_WDAY;
                end
            end
            S_WDAY: begin
                if (r_wcnt != 2'd3) begin
                    n_wcnt = r_wcnt + 2'd1;
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oyear  = r_y[SY_W-1:0];
                    n_omonth = r_m;
                    n_oday   = r_d[DAY_W-1:0];
                    n_oweek  = wd;
                    n_oerr   = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oyear  = r_sy;
                    n_omonth = r_sm;
                    n_oday   = r_sd;
                    n_oweek  = '0;
                    n_oerr   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_wcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_wcnt   <= n_wcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_back   <= n_back;
        r_y      <= n_y;
        r_m      <= n_m;
        r_d      <= n_d;
        r_ymod   <= n_ymod;
        r_q400   <= n_q400;
        r_sy     <= n_sy;
        r_sm     <= n_sm;
        r_sd     <= n_sd;
        r_oyear  <= n_oyear;
        r_omonth <= n_omonth;
        r_oday   <= n_oday;
        r_oweek  <= n_oweek;
        r_oerr   <= n_oerr;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_end_year    = r_oyear;
    assign o_end_month   = r_omonth;
    assign o_end_day     = r_oday;
    assign o_weekday     = r_oweek;
    assign o_range_error = r_oerr;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("block took a beat but did not go busy");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_WDAY || $past(r_state) == S_ERR))
        else $error("result appeared outside a finishing state");

    a_error_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |-> (o_weekday == '0))
        else $error("error result carries a weekday");

    a_good_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_range_error) |->
        (o_end_year >= SY_W'(YEAR_MIN) && o_end_year <= SY_W'(YEAR_MAX)
         && o_end_month >= MON_W'(MONTH_JAN) && o_end_month <= MON_W'(MONTH_DEC)
         && o_weekday <= 3'd6))
        else $error("good result outside calendar range");

    a_walk_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CYC || r_state == S_MON) |->
        (r_m >= MON_W'(MONTH_JAN) && r_m <= MON_W'(MONTH_DEC)))
        else $error("month left 1..12 during the walk");

endmodule

/* design/gdo_step_unit.sv */
// shared day adder: one month or one 400-year cycle per step, with loop test
module gdo_step_unit
    import gdo_pkg::*;
#(
    parameter int DW = 19
) (
    input  t_step_ctl               i_ctl,
    input  logic [MON_W-1:0]        i_month,
    input  logic [YMOD_W-1:0]       i_ymod,
    input  logic signed [DW-1:0]    i_day,
    output logic signed [DW-1:0]    o_day_next,
    output logic                    o_more
);

    localparam logic signed [DW-1:0] FWD_CYC_LIMIT = DW'(CYCLE_DAYS + 31);
    localparam logic signed [DW-1:0] BWD_CYC_LIMIT = DW'(1 - CYCLE_DAYS);
    localparam logic signed [DW-1:0] CYC_STEP      = DW'(CYCLE_DAYS);

    logic [MON_W-1:0]         len_month;
    logic [DAY_W-1:0]         len;
    logic signed [DW-1:0]     len_ext;
    logic signed [DW-1:0]     operand;

    always_comb begin
        len_month = i_month;
        if (i_ctl.back) begin
            len_month = (i_month == MON_W'(MONTH_JAN)) ? MON_W'(MONTH_DEC)
                                                       : i_month - 4'd1;
        end
        len     = month_days(len_month, is_leap(i_ymod));
        len_ext = {{(DW-DAY_W){1'b0}}, len};
        operand = i_ctl.cycle ? CYC_STEP : len_ext;
        o_day_next = i_ctl.back ? i_day + operand : i_day - operand;
        case ({i_ctl.cycle, i_ctl.back})
            2'b10:   o_more = i_day > FWD_CYC_LIMIT;
            2'b11:   o_more = i_day < BWD_CYC_LIMIT;
            2'b00:   o_more = i_day > len_ext;
            default: o_more = i_day[DW-1] || (i_day == '0);
        endcase
    end

endmodule

/* design/gdo_weekday.sv */
// three-stage weekday pipeline, zeller-style formula with constant reciprocals
module gdo_weekday
    import gdo_pkg::*;
(
    input  logic               i_clk,
    input  logic [SY_W-1:0]    i_year,
    input  logic [MON_W-1:0]   i_month,
    input  logic [DAY_W-1:0]   i_day,
    output logic [WD_W-1:0]    o_weekday
);

    logic [SY_W-1:0]  ya;
    logic [26:0]      prod100;
    logic [6:0]       md;
    logic [29:0]      prod7;
    logic [SY_W-1:0]  n_v;

    logic [SY_W-1:0]  r_ya;
    logic [6:0]       r_q100;
    logic [6:0]       r_md;
    logic [SY_W-1:0]  r_v;
    logic [SY_W-1:0]  r_v2;
    logic [10:0]      r_q7;

    always_comb begin
        ya = ((i_month == MON_W'(MONTH_JAN)) || (i_month == MON_W'(MONTH_FEB)))
           ? i_year - 14'd1 : i_year;
        prod100 = {13'b0, ya} * 27'(DIV100_MUL);
        md      = {1'b0, month_term(i_month)} + {2'b0, i_day};
        n_v     = r_ya + {2'b0, r_ya[SY_W-1:2]} - {7'b0, r_q100}
                + {9'b0, r_q100[6:2]} + {7'b0, r_md};
        prod7   = {16'b0, r_v} * 30'(DIV7_MUL);
    end

    always_ff @(posedge i_clk) begin
        r_ya   <= ya;
        r_q100 <= prod100[25:19];
        r_md   <= md;
        r_v    <= n_v;
        r_v2   <= r_v;
        r_q7   <= prod7[28:18];
    end

    assign o_weekday = WD_W'(r_v2 - ({3'b0, r_q7} * 14'd7));

endmodule

/* test/testbench.sv */
// self-checking testbench for the gregorian date offset block
module testbench;
    import gdo_pkg::*;

    localparam int OFFSET_BITS = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 120;
    localparam bit OP_FORWARD = 1'b0;
    localparam bit OP_BACK = 1'b1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        logic                          op;
        logic [SY_W-1:0]               year;
        logic [MON_W-1:0]              month;
        logic [DAY_W-1:0]              day;
        logic signed [OFFSET_BITS-1:0] offset;
    } t_date_item;

    typedef struct {
        logic [SY_W-1:0]  year;
        logic [MON_W-1:0] month;
        logic [DAY_W-1:0] day;
        logic [WD_W-1:0]  weekday;
        logic             err;
    } t_date_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_operation = 1'b0;
    logic [SY_W-1:0]               i_start_year = '0;
    logic [MON_W-1:0]              i_start_month = '0;
    logic [DAY_W-1:0]              i_start_day = '0;
    logic signed [OFFSET_BITS-1:0] i_day_offset = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [SY_W-1:0]               o_end_year;
    logic [MON_W-1:0]              o_end_month;
    logic [DAY_W-1:0]              o_end_day;
    logic [WD_W-1:0]               o_weekday;
    logic                          o_range_error;

    t_date_item   pending_dates[$];
    t_date_result expected_dates[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int n_forward = 0;
    int n_back = 0;
    int n_checked = 0;
    int n_flagged = 0;
    int quiet_cycles = 0;

    gregorian_date_offset_top #(
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_start_year  (i_start_year),
        .i_start_month (i_start_month),
        .i_start_day   (i_start_day),
        .i_day_offset  (i_day_offset),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_end_year    (o_end_year),
        .o_end_month   (o_end_month),
        .o_end_day     (o_end_day),
        .o_weekday     (o_weekday),
        .o_range_error (o_range_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit leap_of(longint y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    function automatic longint month_len_of(longint y, longint m);
        case (m)
            2:              return leap_of(y) ? 29 : 28;
            4, 6, 9, 11:    return 30;
            default:        return 31;
        endcase
    endfunction

    // skips whole 400-year cycles, walks the date month by month and derives the weekday
    function automatic t_date_result shift_date(t_date_item it);
        t_date_result r;
        longint y, m, d, n, wy, wm, v;
        y = it.year;
        m = it.month;
        d = it.day;
        n = it.offset;
        if (n < 0) n = -n;
        r.year = it.year;
        r.month = it.month;
        r.day = it.day;
        r.weekday = '0;
        r.err = 1'b1;
        if (m < MONTH_JAN || m > MONTH_DEC) return r;
        if (it.op == OP_FORWARD) begin
            d += n;
            while (d > CYCLE_DAYS + 31) begin
                d -= CYCLE_DAYS;
                y += CYCLE_YEARS;
            end
            while (d > month_len_of(y, m)) begin
                d -= month_len_of(y, m);
                m++;
                if (m > MONTH_DEC) begin
                    y++;
                    m = MONTH_JAN;
                end
            end
        end else begin
            d -= n;
            while (d + CYCLE_DAYS < 1) begin
                d += CYCLE_DAYS;
                y -= CYCLE_YEARS;
            end
            while (d < 1) begin
                m--;
                if (m < MONTH_JAN) begin
                    y--;
                    m = MONTH_DEC;
                end
                d += month_len_of(y, m);
            end
        end
        if (y < YEAR_MIN || y > YEAR_MAX) return r;
        wy = y;
        wm = m;
        if (wm <= MONTH_FEB) begin
            wy--;
            wm += 12;
        end
        v = wy + wy / 4 - wy / 100 + wy / 400 + (13 * wm + 8) / 5 + d;
        v %= 7;
        if (v < 0) v += 7;
        r.year = y[SY_W-1:0];
        r.month = m[MON_W-1:0];
        r.day = d[DAY_W-1:0];
        r.weekday = v[WD_W-1:0];
        r.err = 1'b0;
        return r;
    endfunction

    task automatic queue_date(logic op, int y, int m, int d, int off);
        t_date_item it;
        it.op = op;
        it.year = y[SY_W-1:0];
        it.month = m[MON_W-1:0];
        it.day = d[DAY_W-1:0];
        it.offset = off[OFFSET_BITS-1:0];
        pending_dates.push_back(it);
    endtask

    // mostly calendar-valid dates with random offsets, the rest raw noise
    task automatic queue_random_phase(int count);
        int y, m, d, mag, sel;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 80) begin
                sel = $urandom_range(9);
                if (sel == 0) y = $urandom_range(3, 1);
                else if (sel == 1) y = $urandom_range(YEAR_MAX, YEAR_MAX - 2);
                else y = $urandom_range(YEAR_MAX, YEAR_MIN);
                m = $urandom_range(MONTH_DEC, MONTH_JAN);
                d = $urandom_range(month_len_of(y, m), 1);
                if ($urandom_range(99) < 60) mag = $urandom_range(400);
                else mag = $urandom_range(32767);
                if ($urandom_range(1)) mag = -mag;
                queue_date(1'($urandom_range(1)), y, m, d, mag);
            end else begin
                queue_date(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    always @(posedge i_clk) begin : drive_dates
        t_date_item it;
        t_date_item taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                taken.op = i_operation;
                taken.year = i_start_year;
                taken.month = i_start_month;
                taken.day = i_start_day;
                taken.offset = i_day_offset;
                expected_dates.push_back(shift_date(taken));
                if (i_operation == OP_FORWARD) n_forward++;
                else n_back++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_dates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = pending_dates.pop_front();
                    i_operation <= it.op;
                    i_start_year <= it.year;
                    i_start_month <= it.month;
                    i_start_day <= it.day;
                    i_day_offset <= it.offset;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_dates
        t_date_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_dates.size() == 0) begin
                $error("result beat with no date pending");
                fail_count++;
            end else begin
                want = expected_dates.pop_front();
                n_checked++;
                if (want.err) n_flagged++;
                if (o_end_year !== want.year) begin
                    $error("end_year: expected %0d, got %0d", want.year, o_end_year);
                    fail_count++;
                end
                if (o_end_month !== want.month) begin
                    $error("end_month: expected %0d, got %0d", want.month, o_end_month);
                    fail_count++;
                end
                if (o_end_day !== want.day) begin
                    $error("end_day: expected %0d, got %0d", want.day, o_end_day);
                    fail_count++;
                end
                if (o_weekday !== want.weekday) begin
                    $error("weekday: expected %0d, got %0d", want.weekday, o_weekday);
                    fail_count++;
                end
                if (o_range_error !== want.err) begin
                    $error("range_error: expected %0d, got %0d", want.err, o_range_error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("handshake timeout after %0d quiet cycles", quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_idle_mode mode;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // leap rules, range edges, odd months and days, offset extremes
        queue_date(OP_FORWARD, 2000, 2, 28, 1);
        queue_date(OP_FORWARD, 1900, 2, 28, 1);
        queue_date(OP_BACK, 2000, 3, 1, 1);
        queue_date(OP_BACK, 2100, 3, 1, -1);
        queue_date(OP_FORWARD, 2024, 6, 15, -32768);
        queue_date(OP_BACK, 2024, 6, 15, -32768);
        queue_date(OP_FORWARD, 1, 1, 1, 32767);
        queue_date(OP_BACK, 9999, 12, 31, 32767);
        queue_date(OP_BACK, 1, 1, 1, 1);
        queue_date(OP_FORWARD, 9999, 12, 31, 1);
        queue_date(OP_BACK, 1, 1, 1, 0);
        queue_date(OP_FORWARD, 9999, 12, 31, 0);
        queue_date(OP_FORWARD, 2023, 0, 10, 5);
        queue_date(OP_BACK, 2023, 13, 10, 5);
        queue_date(OP_FORWARD, 2023, 15, 31, -32768);
        queue_date(OP_FORWARD, 2023, 2, 31, 0);
        queue_date(OP_FORWARD, 2023, 5, 0, 0);
        queue_date(OP_BACK, 2023, 5, 0, 0);
        queue_date(OP_BACK, 2023, 4, 31, 0);
        queue_date(OP_FORWARD, 0, 12, 31, 1);
        queue_date(OP_BACK, 10000, 3, 1, 32767);
        queue_date(OP_BACK, 16383, 15, 31, 32767);
        queue_date(OP_BACK, 16383, 7, 31, -32767);

        mode = IDLE_NONE;
        for (int phase = 0; phase < 5; phase++) begin
            if (phase > 0) begin
                mode = t_idle_mode'(phase - 1);
                case (mode)
                    IDLE_NONE: begin
                        send_idle_pct = 0;
                        recv_stall_pct = 0;
                    end
                    IDLE_SENDER: begin
                        send_idle_pct = 87;
                        recv_stall_pct = 0;
                    end
                    IDLE_RECEIVER: begin
                        send_idle_pct = 0;
                        recv_stall_pct = 87;
                    end
                    default: begin
                        send_idle_pct = 29;
                        recv_stall_pct = 29;
                    end
                endcase
                queue_random_phase(PHASE_ITEMS);
            end
            // hold the sender off until every result of this phase is back
            while (pending_dates.size() != 0 || i_in_valid || expected_dates.size() != 0)
                @(negedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_dates.size() != 0) begin
            $error("%0d results never arrived", expected_dates.size());
            fail_count++;
        end
        $display("dates moved: %0d forward, %0d back; %0d results checked, %0d flagged",
                 n_forward, n_back, n_checked, n_flagged);
        $display("phases run: directed, then random with no idling, sender gaps, "
                 , "receiver stalls and both");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
